[hdl/neighbor_table_with_aging_defines.svh]
// Assertion macros shared by the neighbor table RTL.
`ifndef NEIGHBOR_TABLE_WITH_AGING_DEFINES_SVH
`define NEIGHBOR_TABLE_WITH_AGING_DEFINES_SVH

`ifndef SYNTH

`define NTA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("neighbor table assertion failed");

`define NTA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("neighbor table implication failed");

`define NTA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("neighbor table sequence failed");

`else

`define NTA_ASSERT(lbl, clk, rstn, prop)
`define NTA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define NTA_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[hdl/nta_pkg.sv]
// Package with codes, constants and the token type of the neighbor table.
package nta_pkg;

  localparam int NeighborSlotsDef = 8;
  localparam int NeighborSlotsMax = 64;
  localparam int SlotIdxW = $clog2(NeighborSlotsMax);

  localparam logic [31:0] TimeoutReset = 32'd3000000;

  localparam int CfgAddrW = 3;
  localparam logic RegTimeout = 1'b0;

  localparam logic [1:0] CMD_UPDATE = 2'd0;
  localparam logic [1:0] CMD_PRUNE  = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] STAT_UPDATED = 2'd0;
  localparam logic [1:0] STAT_ALLOC   = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_DONE    = 2'd3;

  typedef enum logic [1:0] {
    TOK_SCAN,
    TOK_PRUNE,
    TOK_READ,
    TOK_WRITE
  } tok_op_e;

  // A request token travels down the row of cells, one cell per cycle.
  typedef struct packed {
    logic                vld;
    tok_op_e             op;
    logic [47:0]         mac;
    logic [31:0]         x;
    logic [31:0]         y;
    logic [31:0]         hdg;
    logic [63:0]         tim;
    logic                hit;
    logic [SlotIdxW-1:0] hidx;
    logic                free;
    logic [SlotIdxW-1:0] fidx;
    logic [3:0]          cnt;
  } token_t;

endpackage

[hdl/nta_cell.sv]
// One table slot: holds its entry and handles the token passing through it.
module nta_cell #(
  parameter int CellIdx = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [31:0]      timeout_i,
  input  nta_pkg::token_t  tok_i,
  output nta_pkg::token_t  tok_o
);

  logic                    valid_q, valid_d;
  logic [47:0]             key_q, key_d;
  logic [31:0]             x_q, x_d;
  logic [31:0]             y_q, y_d;
  logic [31:0]             hdg_q, hdg_d;
  logic [63:0]             seen_q, seen_d;
  nta_pkg::token_t         tok_q, tok_d;
  logic                    sel;
  logic [63:0]             age;

  assign sel = (tok_i.hidx == nta_pkg::SlotIdxW'(CellIdx));
  assign age = tok_i.tim - seen_q;

  always_comb begin
    tok_d   = tok_i;
    valid_d = valid_q;
    key_d   = key_q;
    x_d     = x_q;
    y_d     = y_q;
    hdg_d   = hdg_q;
    seen_d  = seen_q;
    if (tok_i.vld) begin
      case (tok_i.op)
        nta_pkg::TOK_SCAN: begin
          if (!tok_i.hit && valid_q && (key_q == tok_i.mac)) begin
            tok_d.hit  = 1'b1;
            tok_d.hidx = nta_pkg::SlotIdxW'(CellIdx);
          end
          if (!tok_i.free && !valid_q) begin
            tok_d.free = 1'b1;
            tok_d.fidx = nta_pkg::SlotIdxW'(CellIdx);
          end
        end
        nta_pkg::TOK_PRUNE: begin
          if (valid_q && (age > 64'(timeout_i))) begin
            valid_d   = 1'b0;
            tok_d.cnt = tok_i.cnt + 4'd1;
          end
        end
        nta_pkg::TOK_READ: begin
          if (sel) begin
            tok_d.hit = valid_q;
            tok_d.mac = key_q;
            tok_d.x   = x_q;
            tok_d.y   = y_q;
            tok_d.hdg = hdg_q;
            tok_d.tim = seen_q;
          end
        end
        nta_pkg::TOK_WRITE: begin
          if (sel) begin
            x_d    = tok_i.x;
            y_d    = tok_i.y;
            hdg_d  = tok_i.hdg;
            seen_d = tok_i.tim;
            if (tok_i.hit) begin
              valid_d = 1'b1;
              key_d   = tok_i.mac;
            end
          end
        end
        default: begin
          tok_d = tok_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      key_q   <= '0;
      x_q     <= '0;
      y_q     <= '0;
      hdg_q   <= '0;
      seen_q  <= '0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      key_q   <= key_d;
      x_q     <= x_d;
      y_q     <= y_d;
      hdg_q   <= hdg_d;
      seen_q  <= seen_d;
      tok_q   <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

[hdl/neighbor_table_with_aging.sv]
// Top level of the neighbor table: request control, register port and row of slot cells.
// An update makes a scan pass and, unless the table is full, a write pass down the cell row.
// A prune or a read makes one pass down the row; an unused command makes none.
// One request is in flight at a time; busy is high until its result strobe.
// The result is shown for one cycle on done_o; the receiver cannot stall it.
// Reset clears every slot and sets the timeout register to 3000000.
`include "neighbor_table_with_aging_defines.svh"

module neighbor_table_with_aging #(
  parameter int NeighborSlots = nta_pkg::NeighborSlotsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [nta_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   cmd_i,
  input  logic [47:0]                  src_mac_i,
  input  logic [31:0]                  pos_x_i,
  input  logic [31:0]                  pos_y_i,
  input  logic [31:0]                  heading_i,
  input  logic [63:0]                  time_us_i,
  input  logic [2:0]                   read_slot_i,
  output logic                         done_o,
  output logic [1:0]                   status_o,
  output logic [2:0]                   slot_o,
  output logic [3:0]                   expired_count_o,
  output logic                         entry_active_o,
  output logic [47:0]                  entry_mac_o,
  output logic [31:0]                  entry_x_o,
  output logic [31:0]                  entry_y_o,
  output logic [31:0]                  entry_heading_o,
  output logic [63:0]                  entry_seen_us_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PASS1,
    ST_PASS2
  } state_e;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  slot;
    logic [3:0]  cnt;
    logic        active;
    logic [47:0] mac;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] hdg;
    logic [63:0] seen;
  } res_t;

  state_e              state_q;
  nta_pkg::token_t     inj_q;
  nta_pkg::token_t     req_tok;
  nta_pkg::token_t     wr_tok;
  nta_pkg::token_t     chain_out;
  nta_pkg::token_t     tok [NeighborSlots+1];
  logic [NeighborSlots:0] tok_vld;
  res_t                res_q, res_d;
  logic                done_q;
  logic [31:0]         timeout_q;
  logic                accept;
  logic                launch;
  logic                cfg_wr;
  logic                reg_sel;
  logic                full_rsp;
  logic                rsp_clean;

  // Configuration register.
  assign reg_sel = (paddr[nta_pkg::CfgAddrW-1] == nta_pkg::RegTimeout);
  assign cfg_wr  = psel && penable && pwrite && reg_sel;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? timeout_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= nta_pkg::TimeoutReset;
    end else if (cfg_wr) begin
      timeout_q <= pwdata;
    end
  end

  // Cell row.
  assign tok[0] = inj_q;

  for (genvar k = 0; k < NeighborSlots; k++) begin : g_cell
    nta_cell #(
      .CellIdx(k)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .timeout_i(timeout_q),
      .tok_i    (tok[k]),
      .tok_o    (tok[k+1])
    );
  end

  for (genvar k = 0; k <= NeighborSlots; k++) begin : g_vld
    assign tok_vld[k] = tok[k].vld;
  end

  assign chain_out = tok[NeighborSlots];
  assign busy      = (state_q != ST_IDLE);
  assign accept    = start && !busy;
  assign launch    = accept && (cmd_i != nta_pkg::CMD_UNUSED);

  always_comb begin
    req_tok      = '0;
    req_tok.vld  = 1'b1;
    req_tok.op   = nta_pkg::TOK_SCAN;
    req_tok.mac  = src_mac_i;
    req_tok.x    = pos_x_i;
    req_tok.y    = pos_y_i;
    req_tok.hdg  = heading_i;
    req_tok.tim  = time_us_i;
    unique case (cmd_i)
      nta_pkg::CMD_PRUNE: begin
        req_tok.op  = nta_pkg::TOK_PRUNE;
        req_tok.mac = '0;
        req_tok.x   = '0;
        req_tok.y   = '0;
        req_tok.hdg = '0;
      end
      nta_pkg::CMD_READ: begin
        req_tok.op   = nta_pkg::TOK_READ;
        req_tok.mac  = '0;
        req_tok.x    = '0;
        req_tok.y    = '0;
        req_tok.hdg  = '0;
        req_tok.tim  = '0;
        req_tok.hidx = nta_pkg::SlotIdxW'(read_slot_i);
      end
      default: begin
        req_tok.op = nta_pkg::TOK_SCAN;
      end
    endcase
  end

  always_comb begin
    wr_tok      = chain_out;
    wr_tok.vld  = 1'b1;
    wr_tok.op   = nta_pkg::TOK_WRITE;
    wr_tok.hit  = !chain_out.hit;
    wr_tok.hidx = chain_out.hit ? chain_out.hidx : chain_out.fidx;
  end

  always_comb begin
    res_d        = '0;
    res_d.status = nta_pkg::STAT_DONE;
    if (state_q != ST_IDLE) begin
      case (chain_out.op)
        nta_pkg::TOK_SCAN: begin
          res_d.status = nta_pkg::STAT_FULL;
        end
        nta_pkg::TOK_PRUNE: begin
          res_d.cnt = chain_out.cnt;
        end
        nta_pkg::TOK_READ: begin
          res_d.slot   = chain_out.hidx[2:0];
          res_d.active = chain_out.hit;
          res_d.mac    = chain_out.mac;
          res_d.x      = chain_out.x;
          res_d.y      = chain_out.y;
          res_d.hdg    = chain_out.hdg;
          res_d.seen   = chain_out.tim;
        end
        nta_pkg::TOK_WRITE: begin
          res_d.status = chain_out.hit ? nta_pkg::STAT_ALLOC : nta_pkg::STAT_UPDATED;
          res_d.slot   = chain_out.hidx[2:0];
        end
        default: begin
          res_d.status = nta_pkg::STAT_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      inj_q   <= '0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (launch) begin
            inj_q   <= req_tok;
            done_q  <= 1'b0;
            state_q <= ST_PASS1;
          end else begin
            inj_q.vld <= 1'b0;
            done_q    <= accept;
            if (accept) begin
              res_q <= res_d;
            end
          end
        end
        ST_PASS1: begin
          if (chain_out.vld && (chain_out.op == nta_pkg::TOK_SCAN) &&
              (chain_out.hit || chain_out.free)) begin
            inj_q   <= wr_tok;
            done_q  <= 1'b0;
            state_q <= ST_PASS2;
          end else begin
            inj_q.vld <= 1'b0;
            done_q    <= chain_out.vld;
            if (chain_out.vld) begin
              res_q   <= res_d;
              state_q <= ST_IDLE;
            end
          end
        end
        ST_PASS2: begin
          inj_q.vld <= 1'b0;
          done_q    <= chain_out.vld;
          if (chain_out.vld) begin
            res_q   <= res_d;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          inj_q.vld <= 1'b0;
          done_q    <= 1'b0;
          state_q   <= ST_IDLE;
        end
      endcase
    end
  end

  assign done_o          = done_q;
  assign status_o        = res_q.status;
  assign slot_o          = res_q.slot;
  assign expired_count_o = res_q.cnt;
  assign entry_active_o  = res_q.active;
  assign entry_mac_o     = res_q.mac;
  assign entry_x_o       = res_q.x;
  assign entry_y_o       = res_q.y;
  assign entry_heading_o = res_q.hdg;
  assign entry_seen_us_o = res_q.seen;

  assign full_rsp  = done_o && (status_o == nta_pkg::STAT_FULL);
  assign rsp_clean = (slot_o == 3'd0) && (expired_count_o == 4'd0) && !entry_active_o;

  `NTA_ASSERT(a_one_token, clk_i, rst_ni, $countones(tok_vld) <= 1)
  `NTA_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_o, !busy)
  `NTA_ASSERT_IMP(a_full_clean, clk_i, rst_ni, full_rsp, rsp_clean)
  `NTA_ASSERT_NXT(a_go_busy, clk_i, rst_ni, launch, busy && !done_o)
  `NTA_ASSERT_IMP(a_token_busy, clk_i, rst_ni, chain_out.vld, busy)

endmodule

[tb/neighbor_table_with_aging_tb.sv]
// Self-checking testbench for the neighbor table: directed rows, then random requests.
`timescale 1ns / 1ps

module neighbor_table_with_aging_tb;

  localparam int Slots = nta_pkg::NeighborSlotsDef;
  localparam int PoolSize = 12;
  localparam int ItemsPerPhase = 410;
  localparam logic [1:0] CmdUnused = nta_pkg::CMD_UNUSED;
  localparam logic [nta_pkg::CfgAddrW-1:0] TimeoutAddr =
    nta_pkg::CfgAddrW'(4 * nta_pkg::RegTimeout);

  typedef struct packed {
    logic [1:0]  cmd;
    logic [47:0] mac;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] hdg;
    logic [63:0] tim;
    logic [2:0]  rslot;
  } nbr_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  slot;
    logic [3:0]  expired;
    logic        active;
    logic [47:0] mac;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] hdg;
    logic [63:0] seen;
  } nbr_rsp_t;

  typedef struct packed {
    nbr_req_t req;
    logic     typed;
    nbr_rsp_t rsp;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [nta_pkg::CfgAddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  cmd_i = '0;
  logic [47:0] src_mac_i = '0;
  logic [31:0] pos_x_i = '0;
  logic [31:0] pos_y_i = '0;
  logic [31:0] heading_i = '0;
  logic [63:0] time_us_i = '0;
  logic [2:0]  read_slot_i = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [2:0]  slot_o;
  logic [3:0]  expired_count_o;
  logic        entry_active_o;
  logic [47:0] entry_mac_o;
  logic [31:0] entry_x_o;
  logic [31:0] entry_y_o;
  logic [31:0] entry_heading_o;
  logic [63:0] entry_seen_us_o;

  logic        nbr_valid [Slots];
  logic [47:0] nbr_mac [Slots];
  logic [31:0] nbr_x [Slots];
  logic [31:0] nbr_y [Slots];
  logic [31:0] nbr_hdg [Slots];
  logic [63:0] nbr_seen [Slots];
  logic [31:0] expire_limit_us = nta_pkg::TimeoutReset;

  nbr_rsp_t pending_responses [$];
  dir_row_t directed_rows [$];
  int       mismatch_count = 0;

  neighbor_table_with_aging u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .src_mac_i      (src_mac_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .heading_i      (heading_i),
    .time_us_i      (time_us_i),
    .read_slot_i    (read_slot_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .expired_count_o(expired_count_o),
    .entry_active_o (entry_active_o),
    .entry_mac_o    (entry_mac_o),
    .entry_x_o      (entry_x_o),
    .entry_y_o      (entry_y_o),
    .entry_heading_o(entry_heading_o),
    .entry_seen_us_o(entry_seen_us_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    for (int i = 0; i < Slots; i++) begin
      nbr_valid[i] = 1'b0;
      nbr_mac[i]   = '0;
      nbr_x[i]     = '0;
      nbr_y[i]     = '0;
      nbr_hdg[i]   = '0;
      nbr_seen[i]  = '0;
    end
  end

  function automatic nbr_rsp_t predict_table_response(input nbr_req_t r);
    nbr_rsp_t rsp;
    int       hit;
    int       free_idx;
    logic [3:0] cleared;
    rsp = '0;
    hit = -1;
    free_idx = -1;
    cleared = '0;
    rsp.status = nta_pkg::STAT_DONE;
    case (r.cmd)
      nta_pkg::CMD_UPDATE: begin
        for (int i = 0; i < Slots; i++) begin
          if (hit < 0 && nbr_valid[i] && nbr_mac[i] == r.mac) hit = i;
        end
        if (hit < 0) begin
          for (int i = 0; i < Slots; i++) begin
            if (free_idx < 0 && !nbr_valid[i]) free_idx = i;
          end
        end
        if (hit < 0 && free_idx < 0) begin
          rsp.status = nta_pkg::STAT_FULL;
        end else begin
          if (hit < 0) begin
            hit = free_idx;
            nbr_valid[hit] = 1'b1;
            nbr_mac[hit] = r.mac;
            rsp.status = nta_pkg::STAT_ALLOC;
          end else begin
            rsp.status = nta_pkg::STAT_UPDATED;
          end
          nbr_x[hit]    = r.x;
          nbr_y[hit]    = r.y;
          nbr_hdg[hit]  = r.hdg;
          nbr_seen[hit] = r.tim;
          rsp.slot = 3'(hit);
        end
      end
      nta_pkg::CMD_PRUNE: begin
        for (int i = 0; i < Slots; i++) begin
          if (nbr_valid[i] && (r.tim - nbr_seen[i]) > {32'd0, expire_limit_us}) begin
            nbr_valid[i] = 1'b0;
            cleared++;
          end
        end
        rsp.expired = cleared;
      end
      nta_pkg::CMD_READ: begin
        rsp.slot   = r.rslot;
        rsp.active = nbr_valid[r.rslot];
        rsp.mac    = nbr_mac[r.rslot];
        rsp.x      = nbr_x[r.rslot];
        rsp.y      = nbr_y[r.rslot];
        rsp.hdg    = nbr_hdg[r.rslot];
        rsp.seen   = nbr_seen[r.rslot];
      end
      default: begin
      end
    endcase
    return rsp;
  endfunction

  task automatic send_request(input nbr_req_t r, input logic typed, input nbr_rsp_t given);
    nbr_rsp_t predicted;
    cmd_i       <= r.cmd;
    src_mac_i   <= r.mac;
    pos_x_i     <= r.x;
    pos_y_i     <= r.y;
    heading_i   <= r.hdg;
    time_us_i   <= r.tim;
    read_slot_i <= r.rslot;
    start       <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    predicted = predict_table_response(r);
    pending_responses.push_back(typed ? given : predicted);
  endtask

  task automatic idle_gap(input int gap_pct);
    if ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic drain_responses();
    start <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_timeout(input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TimeoutAddr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    expire_limit_us = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata !== value) begin
      $error("expire_timeout_us readback: expected %h, got %h", value, prdata);
      mismatch_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin : response_check
    nbr_rsp_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_responses.size() == 0) begin
        $error("response strobe with no request outstanding");
        mismatch_count++;
      end else begin
        want = pending_responses.pop_front();
        check_field("status", 64'(want.status), 64'(status_o));
        check_field("slot", 64'(want.slot), 64'(slot_o));
        check_field("expired_count", 64'(want.expired), 64'(expired_count_o));
        check_field("entry_active", 64'(want.active), 64'(entry_active_o));
        check_field("entry_mac", 64'(want.mac), 64'(entry_mac_o));
        check_field("entry_x", 64'(want.x), 64'(entry_x_o));
        check_field("entry_y", 64'(want.y), 64'(entry_y_o));
        check_field("entry_heading", 64'(want.hdg), 64'(entry_heading_o));
        check_field("entry_seen_us", want.seen, entry_seen_us_o);
      end
    end
  end

  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    nbr_req_t    req;
    logic [31:0] phase_limits [4];
    logic [47:0] mac_pool [PoolSize];
    logic [63:0] now_us;
    int          gap_pct;
    int          sel;

    // Table starts empty; reads and prunes see zeros, cmd 3 does nothing.
    directed_rows.push_back('{'{nta_pkg::CMD_READ, 48'd0, 32'd0, 32'd0, 32'd0, 64'd0, 3'd0}, 1'b1,
      '{nta_pkg::STAT_DONE, 3'd0, 4'd0, 1'b0, 48'd0, 32'd0, 32'd0, 32'd0, 64'd0}});
    directed_rows.push_back('{'{nta_pkg::CMD_READ, 48'd0, 32'd0, 32'd0, 32'd0, 64'd0, 3'd7}, 1'b1,
      '{nta_pkg::STAT_DONE, 3'd7, 4'd0, 1'b0, 48'd0, 32'd0, 32'd0, 32'd0, 64'd0}});
    directed_rows.push_back('{'{nta_pkg::CMD_PRUNE, 48'd0, 32'd0, 32'd0, 32'd0, 64'd0, 3'd0}, 1'b1,
      '{nta_pkg::STAT_DONE, 3'd0, 4'd0, 1'b0, 48'd0, 32'd0, 32'd0, 32'd0, 64'd0}});
    directed_rows.push_back('{'{CmdUnused, '1, '1, '1, '1, '1, 3'd7}, 1'b1,
      '{nta_pkg::STAT_DONE, 3'd0, 4'd0, 1'b0, 48'd0, 32'd0, 32'd0, 32'd0, 64'd0}});
    directed_rows.push_back('{'{nta_pkg::CMD_UPDATE, 48'd0, 32'd0, 32'd0, 32'd0, 64'd0, 3'd0}, 1'b1,
      '{nta_pkg::STAT_ALLOC, 3'd0, 4'd0, 1'b0, 48'd0, 32'd0, 32'd0, 32'd0, 64'd0}});
    directed_rows.push_back('{'{nta_pkg::CMD_UPDATE, '1, '1, '1, '1, '1, 3'd7}, 1'b1,
      '{nta_pkg::STAT_ALLOC, 3'd1, 4'd0, 1'b0, 48'd0, 32'd0, 32'd0, 32'd0, 64'd0}});
    directed_rows.push_back('{'{nta_pkg::CMD_UPDATE, 48'd0, 32'h1234_5678, 32'h8000_0001,
      32'h7FFF_FFFE, 64'd5, 3'd0}, 1'b1,
      '{nta_pkg::STAT_UPDATED, 3'd0, 4'd0, 1'b0, 48'd0, 32'd0, 32'd0, 32'd0, 64'd0}});
    directed_rows.push_back('{'{nta_pkg::CMD_READ, 48'd0, 32'd0, 32'd0, 32'd0, 64'd0, 3'd1}, 1'b1,
      '{nta_pkg::STAT_DONE, 3'd1, 4'd0, 1'b1, '1, '1, '1, '1, '1}});
    directed_rows.push_back('{'{nta_pkg::CMD_READ, 48'd0, 32'd0, 32'd0, 32'd0, 64'd0, 3'd0}, 1'b1,
      '{nta_pkg::STAT_DONE, 3'd0, 4'd0, 1'b1, 48'd0, 32'h1234_5678, 32'h8000_0001,
        32'h7FFF_FFFE, 64'd5}});
    for (int k = 2; k < Slots; k++) begin
      directed_rows.push_back('{'{nta_pkg::CMD_UPDATE, 48'h0000_0100_0000 + 48'(k), 32'(k),
        32'(3 * k), 32'(7 * k), 64'(1000 * k), 3'd0}, 1'b0, '0});
    end
    // Table full: the update is dropped.
    directed_rows.push_back('{'{nta_pkg::CMD_UPDATE, 48'h5A5A_5A5A_5A5A, '1, '1, '1, 64'd9, 3'd0},
      1'b1, '{nta_pkg::STAT_FULL, 3'd0, 4'd0, 1'b0, 48'd0, 32'd0, 32'd0, 32'd0, 64'd0}});
    // Age equal to the limit stays; a seen time after now wraps and is cleared.
    directed_rows.push_back('{'{nta_pkg::CMD_PRUNE, 48'd0, 32'd0, 32'd0, 32'd0, 64'd3000005,
      3'd0}, 1'b0, '0});
    directed_rows.push_back('{'{nta_pkg::CMD_PRUNE, 48'd0, 32'd0, 32'd0, 32'd0, 64'd3002006,
      3'd0}, 1'b0, '0});
    directed_rows.push_back('{'{nta_pkg::CMD_UPDATE, 48'hA5A5_A5A5_A5A5, 32'h0F0F_0F0F,
      32'hF0F0_F0F0, 32'h5555_AAAA, 64'd3002007, 3'd0}, 1'b0, '0});
    directed_rows.push_back('{'{nta_pkg::CMD_READ, 48'd0, 32'd0, 32'd0, 32'd0, 64'd0, 3'd1},
      1'b0, '0});
    directed_rows.push_back('{'{nta_pkg::CMD_READ, 48'd0, 32'd0, 32'd0, 32'd0, 64'd0, 3'd2},
      1'b0, '0});
    directed_rows.push_back('{'{nta_pkg::CMD_PRUNE, 48'd0, 32'd0, 32'd0, 32'd0, '1, 3'd0},
      1'b0, '0});
    directed_rows.push_back('{'{nta_pkg::CMD_PRUNE, 48'd0, 32'd0, 32'd0, 32'd0, 64'd0, 3'd0},
      1'b0, '0});

    phase_limits[0] = 32'd1;
    phase_limits[1] = 32'hFFFF_FFFF;
    phase_limits[2] = $urandom_range(1000, 200000);
    phase_limits[3] = nta_pkg::TimeoutReset;
    now_us = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
      idle_gap(30);
    end
    drain_responses();

    for (int p = 0; p < 4; p++) begin
      program_timeout(phase_limits[p]);
      mac_pool[0] = '0;
      mac_pool[1] = '1;
      for (int m = 2; m < PoolSize; m++) begin
        mac_pool[m] = {16'($urandom), $urandom};
      end
      gap_pct = 0;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (p == 3) begin
          gap_pct = 0;
        end else if (n % 40 == 0) begin
          gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 35;
        end
        sel = $urandom_range(0, 99);
        req.cmd = (sel < 55) ? nta_pkg::CMD_UPDATE : (sel < 70) ? nta_pkg::CMD_PRUNE :
                  (sel < 95) ? nta_pkg::CMD_READ : CmdUnused;
        req.mac = ($urandom_range(0, 19) == 0) ? {16'($urandom), $urandom} :
                  mac_pool[$urandom_range(0, PoolSize - 1)];
        req.x = $urandom;
        req.y = $urandom;
        req.hdg = $urandom;
        req.rslot = 3'($urandom_range(0, Slots - 1));
        now_us = now_us + 64'($urandom_range(0, (phase_limits[p] >> 1) + 32'd1));
        if ($urandom_range(0, 99) == 0) now_us = {$urandom, $urandom};
        req.tim = ($urandom_range(0, 24) == 0) ? {$urandom, $urandom} : now_us;
        send_request(req, 1'b0, '0);
        idle_gap(gap_pct);
      end
      drain_responses();
    end

    repeat (30) @(posedge clk_i);
    if (mismatch_count == 0 && pending_responses.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
